>>> rtl/core/plx_pkg.sv
`default_nettype none
package plx_pkg;

	localparam int MAX_KEYWORD_LEN = 14;
	localparam int POSITION_BITS   = 16;
	localparam int CNT_W           = $clog2(MAX_KEYWORD_LEN + 1);
	localparam int IDX_W           = $clog2(MAX_KEYWORD_LEN);
	localparam int KW_COUNT        = 41;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [CNT_W-1:0]         wcnt_t;
	typedef logic [7:0]               wbuf_t [MAX_KEYWORD_LEN];

	localparam pos_t POS_MAX = {POSITION_BITS{1'b1}};

	// token kinds
	localparam logic [6:0] K_END    = 7'd0;
	localparam logic [6:0] K_IDENT  = 7'd1;
	localparam logic [6:0] K_NUMBER = 7'd2;
	localparam logic [6:0] K_STRING = 7'd3;
	localparam logic [6:0] K_KEY0   = 7'd4;
	localparam logic [6:0] K_ASSIGN = 7'd46;
	localparam logic [6:0] K_COLON  = 7'd47;
	localparam logic [6:0] K_NE     = 7'd48;
	localparam logic [6:0] K_LE     = 7'd49;
	localparam logic [6:0] K_LT     = 7'd50;
	localparam logic [6:0] K_GE     = 7'd51;
	localparam logic [6:0] K_GT     = 7'd52;
	localparam logic [6:0] K_EQ     = 7'd53;
	localparam logic [6:0] K_PLUS   = 7'd54;
	localparam logic [6:0] K_MINUS  = 7'd55;
	localparam logic [6:0] K_STAR   = 7'd56;
	localparam logic [6:0] K_SLASH  = 7'd57;
	localparam logic [6:0] K_LPAREN = 7'd58;
	localparam logic [6:0] K_RPAREN = 7'd59;
	localparam logic [6:0] K_LBRACK = 7'd60;
	localparam logic [6:0] K_RBRACK = 7'd61;
	localparam logic [6:0] K_COMMA  = 7'd62;
	localparam logic [6:0] K_SEMI   = 7'd63;
	localparam logic [6:0] K_DOT    = 7'd64;

	// keywords, right aligned, first letter in the highest used byte
	localparam logic [8*MAX_KEYWORD_LEN-1:0] KW_TEXT [KW_COUNT] = '{
		"algorithm", "structure", "endstructure", "var", "begin", "end",
		"function", "procedure", "beginfunction", "beginprocedure",
		"endfunction", "endprocedure", "return", "integer", "real",
		"boolean", "string", "array", "of", "read", "write", "if", "then",
		"endif", "for", "from", "to", "do", "endfor", "while", "endwhile",
		"repeat", "until", "else", "true", "false", "or", "and", "not",
		"div", "mod"};
	localparam int KW_LEN [KW_COUNT] = '{
		9, 9, 12, 3, 5, 3, 8, 9, 13, 14, 11, 12, 6, 7, 4, 7, 6, 5, 2, 4,
		5, 2, 4, 5, 3, 4, 2, 2, 6, 5, 8, 6, 5, 4, 4, 5, 2, 3, 3, 3, 3};

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_req_t;

	typedef struct packed {
		logic [6:0]  token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic        last_of_run;
	} token_t;

	// all tokens caused by one byte
	typedef struct packed {
		logic [1:0] count;
		token_t [2:0] tok;
	} bundle_t;

	// queue status toward the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/plx_front.sv
`default_nettype none
module plx_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output logic                   byte_stall,
	input  wire plx_pkg::text_req_t byte_data,
	input  wire plx_pkg::q_stat_t  qstat,
	output logic                   push,
	output plx_pkg::bundle_t       push_data
);
	import plx_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_INT, M_FRAC, M_STR, M_COLON, M_LESS, M_GREATER,
		M_SLASH, M_COMMENT
	} mode_t;

	mode_t mode_q, mode_n;
	pos_t  pos_q, pos_n, beg_q, beg_n;
	wbuf_t buf_q, bn;
	wcnt_t cnt_q, cnt_n;
	logic  long_q, long_n;
	logic  accept;
	token_t tk [3];
	logic [1:0] n;

	function automatic logic [15:0] clip(pos_t v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic token_t mk(logic [6:0] k, pos_t s, pos_t e);
		token_t t;
		t.token_kind   = k;
		t.token_start  = clip(s);
		t.token_length = clip((e >= s) ? pos_t'(e - s) : '0);
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction
	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction
	function automatic logic is_space(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// parallel keyword match, lowest table entry wins
	function automatic logic [6:0] word_kind(wbuf_t b, wcnt_t cn, logic lg);
		logic [6:0] k;
		logic hit;
		k = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			hit = !lg && (int'(cn) == KW_LEN[i]);
			for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
				if (j < KW_LEN[i] && b[j] != KW_TEXT[i][8*(KW_LEN[i]-1-j) +: 8])
					hit = 1'b0;
			end
			if (hit) k = 7'(int'(K_KEY0) + i);
		end
		return k;
	endfunction

	function automatic logic [6:0] pend_kind(mode_t m, logic [6:0] wk);
		logic [6:0] k;
		unique case (m)
			M_IDENT:        k = wk;
			M_INT, M_FRAC:  k = K_NUMBER;
			M_STR:          k = K_STRING;
			M_COLON:        k = K_COLON;
			M_LESS:         k = K_LT;
			M_GREATER:      k = K_GT;
			M_SLASH:        k = K_SLASH;
			default:        k = K_END;
		endcase
		return k;
	endfunction

	function automatic logic pend_tok(mode_t m);
		return m != M_IDLE && m != M_COMMENT;
	endfunction

	assign byte_stall = qstat.full;
	assign accept     = byte_valid && !qstat.full;

	// scan one byte: next state and up to three tokens
	always_comb begin
		logic [7:0] c;
		pos_t pn, pend;
		logic rescan, fin;
		logic [6:0] single;
		c = byte_data.text_byte;
		pn = (pos_q == POS_MAX) ? pos_q : pos_t'(pos_q + 1'b1);
		mode_n = mode_q; beg_n = beg_q; pos_n = pos_q;
		bn = buf_q; cnt_n = cnt_q; long_n = long_q;
		n = 2'd0; rescan = 1'b0; single = K_END;
		for (int i = 0; i < 3; i++) tk[i] = '0;
		if (c != 8'd0) begin
			pos_n = pn;
			unique case (mode_q)
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c) || c == "_") begin
						if (int'(cnt_n) < MAX_KEYWORD_LEN) begin
							bn[cnt_n[IDX_W-1:0]] = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
							cnt_n = wcnt_t'(cnt_n + 1'b1);
						end else long_n = 1'b1;
					end else begin
						tk[n] = mk(word_kind(buf_q, cnt_q, long_q), beg_q, pos_q);
						n = n + 2'd1; rescan = 1'b1;
					end
				end
				M_INT, M_FRAC: begin
					if (is_digit(c)) begin
					end else if (c == "." && mode_q == M_INT) mode_n = M_FRAC;
					else begin
						tk[n] = mk(K_NUMBER, beg_q, pos_q);
						n = n + 2'd1; rescan = 1'b1;
					end
				end
				M_STR: begin
					if (c == "\"") begin
						tk[n] = mk(K_STRING, beg_q, pos_q);
						n = n + 2'd1; mode_n = M_IDLE;
					end
				end
				M_COLON, M_LESS, M_GREATER: begin
					if (mode_q == M_COLON && c == "=") single = K_ASSIGN;
					else if (mode_q == M_LESS && c == ">") single = K_NE;
					else if (mode_q == M_LESS && c == "=") single = K_LE;
					else if (mode_q == M_GREATER && c == "=") single = K_GE;
					if (single != K_END) begin
						tk[n] = mk(single, beg_q, pn);
						n = n + 2'd1; mode_n = M_IDLE;
					end else begin
						tk[n] = mk(pend_kind(mode_q, K_IDENT), beg_q, pos_q);
						n = n + 2'd1; rescan = 1'b1;
					end
				end
				M_SLASH: begin
					if (c == "/") mode_n = M_COMMENT;
					else begin
						tk[n] = mk(K_SLASH, beg_q, pos_q);
						n = n + 2'd1; rescan = 1'b1;
					end
				end
				M_COMMENT: if (c == 8'd10) mode_n = M_IDLE;
				default: rescan = 1'b1;
			endcase
			// byte starts something new
			if (rescan) begin
				mode_n = M_IDLE; beg_n = pos_q; single = K_END;
				if (is_space(c)) begin
				end else if (c == "\"") begin
					mode_n = M_STR; beg_n = pn;
				end else if (is_alpha(c) || c == "_") begin
					mode_n = M_IDENT; long_n = 1'b0; cnt_n = wcnt_t'(1);
					bn[0] = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
				end else if (is_digit(c)) mode_n = M_INT;
				else begin
					unique case (c)
						":": mode_n = M_COLON;
						"<": mode_n = M_LESS;
						">": mode_n = M_GREATER;
						"/": mode_n = M_SLASH;
						"#": mode_n = M_COMMENT;
						"=": single = K_EQ;
						"+": single = K_PLUS;
						"-": single = K_MINUS;
						"*": single = K_STAR;
						"(": single = K_LPAREN;
						")": single = K_RPAREN;
						"[": single = K_LBRACK;
						"]": single = K_RBRACK;
						",": single = K_COMMA;
						";": single = K_SEMI;
						".": single = K_DOT;
						default: ;
					endcase
					if (single != K_END) begin
						tk[n] = mk(single, pos_q, pn);
						n = n + 2'd1;
					end
				end
			end
		end
		// end of text: close pending token, end token, back to reset
		fin = (c == 8'd0) || byte_data.end_of_text;
		pend = pos_n;
		if (fin) begin
			if (pend_tok(mode_n)) begin
				tk[n] = mk(pend_kind(mode_n, word_kind(bn, cnt_n, long_n)), beg_n, pend);
				n = n + 2'd1;
			end
			tk[n] = mk(K_END, pend, pend);
			n = n + 2'd1;
			mode_n = M_IDLE; pos_n = '0; beg_n = '0; cnt_n = '0; long_n = 1'b0;
		end
		if (n != 2'd0) tk[n - 2'd1].last_of_run = 1'b1;
	end

	always_comb begin
		push_data.count = n;
		for (int i = 0; i < 3; i++) push_data.tok[i] = tk[i];
		push = accept && (n != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q  <= '0;
			beg_q  <= '0;
			cnt_q  <= '0;
			long_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_n;
			pos_q  <= pos_n;
			beg_q  <= beg_n;
			cnt_q  <= cnt_n;
			long_q <= long_n;
		end
	end

	// word letters: no reset, only written entries are read
	always_ff @(posedge clk) begin
		if (accept) buf_q <= bn;
	end

endmodule
`default_nettype wire

>>> rtl/core/plx_queue.sv
`default_nettype none
module plx_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire plx_pkg::bundle_t push_data,
	input  wire logic             pop,
	output plx_pkg::bundle_t      head,
	output plx_pkg::q_stat_t      qstat
);
	import plx_pkg::*;

	bundle_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   count_q;

	assign head        = mem_q[rd_q];
	assign qstat.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			count_q <= count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/plx_back.sv
`default_nettype none
module plx_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire plx_pkg::bundle_t head,
	input  wire plx_pkg::q_stat_t qstat,
	output logic                  pop,
	output logic                  token_valid,
	input  wire logic             token_stall,
	output plx_pkg::token_t       token_data
);
	import plx_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	token_t     data_q;
	logic       load;

	// output register free or being drained
	assign load  = !qstat.empty && (!valid_q || !token_stall);
	assign pop   = load && (idx_q == head.count - 2'd1);
	assign token_valid = valid_q;
	assign token_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) idx_q <= pop ? 2'd0 : idx_q + 2'd1;
			if (load) valid_q <= 1'b1;
			else if (!token_stall) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) data_q <= head.tok[idx_q];
	end

endmodule
`default_nettype wire

>>> rtl/core/pseudocode_lexer_core.sv
// channel  | handshake                 | payload
// byte     | byte_valid / byte_stall   | byte_data (text_byte, end_of_text)
// token    | token_valid / token_stall | token_data (kind, start, length, last_of_run)
//
// One byte is taken per cycle while the 4-entry bundle queue has room.
// Tokens leave one per cycle unless stalled; a byte's tokens leave one after another.
// A byte's tokens are registered in the queue, then in the output register of plx_back.
// Reset clears scan state and queue.
// token_stall backs up through the queue to byte_stall only when it is full.
`default_nettype none
module pseudocode_lexer_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	output logic                    byte_stall,
	input  wire plx_pkg::text_req_t byte_data,
	output logic                    token_valid,
	input  wire logic               token_stall,
	output plx_pkg::token_t         token_data
);
	import plx_pkg::*;

	logic    push, pop;
	bundle_t push_data, head;
	q_stat_t qstat;

	plx_front u_front (
		.clk, .arst_n, .byte_valid, .byte_stall, .byte_data, .qstat, .push, .push_data
	);

	plx_queue u_queue (
		.clk, .arst_n, .push, .push_data, .pop, .head, .qstat
	);

	plx_back u_back (
		.clk, .arst_n, .head, .qstat, .pop, .token_valid, .token_stall, .token_data
	);

endmodule
`default_nettype wire

>>> rtl/core/plx_checker.sv
`default_nettype none
module plx_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               byte_valid,
	input wire logic               byte_stall,
	input wire plx_pkg::text_req_t byte_data,
	input wire logic               token_valid,
	input wire logic               token_stall,
	input wire plx_pkg::token_t    token_data
);
	import plx_pkg::*;

	// a stalled request stays
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(byte_data))
		else $error("request changed under stall");

	// a stalled token stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid && $stable(token_data))
		else $error("token dropped under stall");

	// end token has no text and closes its run
	a_end_len: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_data.token_kind == K_END |->
		token_data.token_length == 16'd0 && token_data.last_of_run)
		else $error("bad end token");

	// kind stays in range, code 45 never used
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> token_data.token_kind <= K_DOT && token_data.token_kind != 7'd45)
		else $error("bad token kind");

	// nothing comes out the cycle after reset
	a_rst: assert property (@(posedge clk)
		!$past(arst_n) |-> !token_valid)
		else $error("token after reset");

endmodule

bind pseudocode_lexer_core plx_checker u_plx_checker (
	.clk, .arst_n, .byte_valid, .byte_stall, .byte_data, .token_valid, .token_stall,
	.token_data
);
`default_nettype wire
